FILE: rtl/sac_pkg.sv
package sac_pkg;

	localparam int ADDR_BITS = 48;
	localparam int CNT_W     = 32;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SETS   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS   = 2'd3;

	localparam logic [CFG_W-1:0] OFFSET_RST = 4'd4;
	localparam logic [CFG_W-1:0] SETS_RST   = 4'd0;
	localparam logic [CFG_W-1:0] WAYS_RST   = 4'd1;

	localparam logic POLICY_FIFO      = 1'b0;
	localparam logic POLICY_LEAST_USE = 1'b1;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef struct packed {
		logic                 command;
		logic [ADDR_BITS-1:0] address;
	} req_t;

	typedef struct packed {
		logic             hit;
		logic             memory_read;
		logic             memory_write;
		logic             evicted;
		logic [CNT_W-1:0] mem_reads_so_far;
		logic [CNT_W-1:0] mem_writes_so_far;
		logic [CNT_W-1:0] hits_so_far;
		logic [CNT_W-1:0] misses_so_far;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_SCAN,
		ST_UPDATE
	} back_state_t;

endpackage

FILE: rtl/sac_front.sv
module sac_front #(
	parameter int SET_W  = 8,
	parameter int WAYS_W = 4,
	parameter int MAX_WAYS = 8,
	parameter int ENT_W  = 2 + WAYS_W + SET_W + sac_pkg::ADDR_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sac_pkg::CFG_W-1:0]      cfg_wdata,
	input  sac_pkg::req_t                  req,
	output logic [ENT_W-1:0]               ent
);

	logic                        policy_q;
	logic [sac_pkg::CFG_W-1:0]   offset_q;
	logic [sac_pkg::CFG_W-1:0]   setb_q;
	logic [sac_pkg::CFG_W-1:0]   ways_cfg_q;
	logic [sac_pkg::ADDR_BITS-1:0] blk;
	logic [sac_pkg::ADDR_BITS-1:0] tag;
	logic [SET_W-1:0]            set_idx;
	logic [WAYS_W-1:0]           ways;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q   <= sac_pkg::POLICY_FIFO;
			offset_q   <= sac_pkg::OFFSET_RST;
			setb_q     <= sac_pkg::SETS_RST;
			ways_cfg_q <= sac_pkg::WAYS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sac_pkg::CFG_POLICY: policy_q   <= cfg_wdata[0];
				sac_pkg::CFG_OFFSET: offset_q   <= cfg_wdata;
				sac_pkg::CFG_SETS:   setb_q     <= cfg_wdata;
				sac_pkg::CFG_WAYS:   ways_cfg_q <= cfg_wdata;
			endcase
		end
	end

	// split the address; set bits beyond the set store wrap
	always_comb begin
		blk = req.address >> offset_q;
		tag = blk >> setb_q;
		for (int i = 0; i < SET_W; i++) begin
			set_idx[i] = blk[i] & (i < int'(setb_q));
		end
		if (ways_cfg_q == '0) begin
			ways = WAYS_W'(1);
		end else if (int'(ways_cfg_q) > MAX_WAYS) begin
			ways = WAYS_W'(MAX_WAYS);
		end else begin
			ways = WAYS_W'(ways_cfg_q);
		end
	end

	assign ent = {policy_q, req.command, ways, set_idx, tag};

endmodule

FILE: rtl/sac_queue.sv
module sac_queue #(
	parameter int WIDTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] ent_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign full      = (cnt_q == 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_data  = ent_q[rd_ptr_q];

endmodule

FILE: rtl/sac_back.sv
module sac_back #(
	parameter int MAX_SETS = 256,
	parameter int MAX_WAYS = 8,
	parameter int SET_W    = 8,
	parameter int WAYS_W   = 4,
	parameter int WIDX_W   = 3,
	parameter int RANK_W   = 3,
	parameter int ENT_W    = 2 + WAYS_W + SET_W + sac_pkg::ADDR_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ent_valid,
	input  logic [ENT_W-1:0]  ent_data,
	output logic              ent_pop,
	output logic              clear_done,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output sac_pkg::rsp_t     rsp
);

	localparam int AB = sac_pkg::ADDR_BITS;
	localparam int CW = sac_pkg::CNT_W;

	logic [MAX_WAYS-1:0]                vld_mem  [MAX_SETS];
	logic [MAX_WAYS-1:0][AB-1:0]        tag_mem  [MAX_SETS];
	logic [MAX_WAYS-1:0][CW-1:0]        cnt_mem  [MAX_SETS];
	logic [MAX_WAYS-1:0][RANK_W-1:0]    rank_mem [MAX_SETS];

	logic [MAX_WAYS-1:0]                row_vld_q;
	logic [MAX_WAYS-1:0][AB-1:0]        row_tag_q;
	logic [MAX_WAYS-1:0][CW-1:0]        row_cnt_q;
	logic [MAX_WAYS-1:0][RANK_W-1:0]    row_rank_q;

	logic [MAX_WAYS-1:0]                new_vld;
	logic [MAX_WAYS-1:0][AB-1:0]        new_tag;
	logic [MAX_WAYS-1:0][CW-1:0]        new_cnt;
	logic [MAX_WAYS-1:0][RANK_W-1:0]    new_rank;

	sac_pkg::back_state_t state_q, state_d;

	logic [AB-1:0]     tag_q;
	logic [SET_W-1:0]  set_q;
	logic [WAYS_W-1:0] ways_q;
	logic              cmd_q;
	logic              policy_q;
	logic [SET_W-1:0]  clr_q;

	logic              hit_q, full_q;
	logic [WIDX_W-1:0] hway_q, slot_q, vic_q, w_q;
	logic [WAYS_W-1:0] nvalid_q;

	logic [MAX_WAYS-1:0] inr, vmask, hitv;
	logic              hit, full;
	logic [WIDX_W-1:0] hway, slot, fill_way;
	logic [WAYS_W-1:0] nvalid;
	logic [RANK_W-1:0] fill_rank, vr;
	logic              better, scan_last;
	logic              rd_en, vld_we, row_we, upd_fire;
	logic [SET_W-1:0]  wr_set;
	logic              rsp_valid_q;
	sac_pkg::rsp_t     rsp_q;
	logic [CW-1:0]     rd_cnt_q, wr_cnt_q, hit_cnt_q, miss_cnt_q;

	// lookup of the registered row
	always_comb begin
		hway = '0;
		slot = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			inr[w]   = (w < int'(ways_q));
			vmask[w] = row_vld_q[w] & inr[w];
			hitv[w]  = vmask[w] && (row_tag_q[w] == tag_q);
		end
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (hitv[w]) hway = WIDX_W'(w);
			if (inr[w] && !vmask[w]) slot = WIDX_W'(w);
		end
		hit    = |hitv;
		full   = (vmask == inr);
		nvalid = WAYS_W'($countones(vmask));
	end

	// victim scan, one way per cycle
	always_comb begin
		vr = row_rank_q[vic_q];
		if (policy_q == sac_pkg::POLICY_LEAST_USE) begin
			better = (row_cnt_q[w_q] < row_cnt_q[vic_q]) ||
				((row_cnt_q[w_q] == row_cnt_q[vic_q]) && (row_rank_q[w_q] < vr));
		end else begin
			better = row_rank_q[w_q] < vr;
		end
		scan_last = (WAYS_W'(w_q) == ways_q - WAYS_W'(1));
	end

	// updated row
	always_comb begin
		new_vld   = row_vld_q;
		new_tag   = row_tag_q;
		new_cnt   = row_cnt_q;
		new_rank  = row_rank_q;
		fill_way  = slot_q;
		fill_rank = RANK_W'(nvalid_q);
		if (hit_q) begin
			if (row_cnt_q[hway_q] != '1) new_cnt[hway_q] = row_cnt_q[hway_q] + CW'(1);
		end else begin
			if (full_q) begin
				for (int w = 0; w < MAX_WAYS; w++) begin
					if (inr[w] && row_vld_q[w] && (WIDX_W'(w) != vic_q) && (row_rank_q[w] > vr)) begin
						new_rank[w] = row_rank_q[w] - RANK_W'(1);
					end
				end
				fill_way  = vic_q;
				fill_rank = RANK_W'(nvalid_q - WAYS_W'(1));
			end
			new_vld[fill_way]  = 1'b1;
			new_tag[fill_way]  = tag_q;
			new_cnt[fill_way]  = '0;
			new_rank[fill_way] = fill_rank;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sac_pkg::ST_CLEAR:  if (clr_q == SET_W'(MAX_SETS - 1)) state_d = sac_pkg::ST_IDLE;
			sac_pkg::ST_IDLE:   if (ent_valid) state_d = sac_pkg::ST_LOOK;
			sac_pkg::ST_LOOK: begin
				if (!hit && full && ways_q != WAYS_W'(1)) state_d = sac_pkg::ST_SCAN;
				else state_d = sac_pkg::ST_UPDATE;
			end
			sac_pkg::ST_SCAN:   if (scan_last) state_d = sac_pkg::ST_UPDATE;
			sac_pkg::ST_UPDATE: if (!rsp_valid_q || rsp_ready) state_d = sac_pkg::ST_IDLE;
			default:            state_d = sac_pkg::ST_CLEAR;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		upd_fire = (state_q == sac_pkg::ST_UPDATE) && (!rsp_valid_q || rsp_ready);
		ent_pop  = (state_q == sac_pkg::ST_IDLE) && ent_valid;
		rd_en    = ent_pop;
		vld_we   = (state_q == sac_pkg::ST_CLEAR) || upd_fire;
		row_we   = upd_fire;
		wr_set   = (state_q == sac_pkg::ST_CLEAR) ? clr_q : set_q;
		clear_done = (state_q != sac_pkg::ST_CLEAR);
	end

	always_ff @(posedge clk) begin
		if (vld_we) vld_mem[wr_set] <= (state_q == sac_pkg::ST_CLEAR) ? '0 : new_vld;
		if (row_we) begin
			tag_mem[wr_set]  <= new_tag;
			cnt_mem[wr_set]  <= new_cnt;
			rank_mem[wr_set] <= new_rank;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			row_vld_q  <= vld_mem[ent_data[AB +: SET_W]];
			row_tag_q  <= tag_mem[ent_data[AB +: SET_W]];
			row_cnt_q  <= cnt_mem[ent_data[AB +: SET_W]];
			row_rank_q <= rank_mem[ent_data[AB +: SET_W]];
			tag_q      <= ent_data[AB-1:0];
			set_q      <= ent_data[AB +: SET_W];
			ways_q     <= ent_data[AB + SET_W +: WAYS_W];
			cmd_q      <= ent_data[AB + SET_W + WAYS_W];
			policy_q   <= ent_data[ENT_W-1];
		end
		if (state_q == sac_pkg::ST_LOOK) begin
			hit_q    <= hit;
			full_q   <= full;
			hway_q   <= hway;
			slot_q   <= slot;
			nvalid_q <= nvalid;
			vic_q    <= '0;
			w_q      <= WIDX_W'(1);
		end
		if (state_q == sac_pkg::ST_SCAN) begin
			if (better) vic_q <= w_q;
			w_q <= w_q + WIDX_W'(1);
		end
		if (upd_fire) begin
			rsp_q.hit               <= hit_q;
			rsp_q.memory_read       <= !hit_q;
			rsp_q.memory_write      <= (cmd_q == sac_pkg::CMD_WRITE);
			rsp_q.evicted           <= !hit_q && full_q;
			rsp_q.mem_reads_so_far  <= (!hit_q && rd_cnt_q != '1) ? rd_cnt_q + CW'(1) : rd_cnt_q;
			rsp_q.mem_writes_so_far <= (cmd_q == sac_pkg::CMD_WRITE && wr_cnt_q != '1) ?
				wr_cnt_q + CW'(1) : wr_cnt_q;
			rsp_q.hits_so_far       <= (hit_q && hit_cnt_q != '1) ? hit_cnt_q + CW'(1) : hit_cnt_q;
			rsp_q.misses_so_far     <= (!hit_q && miss_cnt_q != '1) ?
				miss_cnt_q + CW'(1) : miss_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sac_pkg::ST_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			rd_cnt_q    <= '0;
			wr_cnt_q    <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == sac_pkg::ST_CLEAR) clr_q <= clr_q + SET_W'(1);
			if (upd_fire) begin
				rsp_valid_q <= 1'b1;
				if (!hit_q && rd_cnt_q != '1) rd_cnt_q <= rd_cnt_q + CW'(1);
				if (cmd_q == sac_pkg::CMD_WRITE && wr_cnt_q != '1) wr_cnt_q <= wr_cnt_q + CW'(1);
				if (hit_q && hit_cnt_q != '1) hit_cnt_q <= hit_cnt_q + CW'(1);
				if (!hit_q && miss_cnt_q != '1) miss_cnt_q <= miss_cnt_q + CW'(1);
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: rtl/set_assoc_cache_hit_miss_model.sv
// Write-through set-associative cache hit/miss model with FIFO or least-use
// replacement. Each accepted req item (command, 48-bit byte address) yields one
// rsp item: hit, memory_read (miss fill), memory_write (write access), evicted,
// and four saturating 32-bit running counters taken after the access. The front
// end splits the address by the configured offset_bits/set_bits and pushes the
// item into a two-entry queue; the back end reads the whole set row from the
// line store, compares tags, picks a victim and writes the row back. An access
// in the back end goes through row read, tag compare and write-back, with a
// victim search before the write-back when a full set has to evict; the victim
// search walks one way per cycle; the way count is ways_in_use clamped to
// 1..MAX_WAYS. After reset a clearing pass over all MAX_SETS sets wipes
// the valid bits; req_ready stays low until it ends. MAX_SETS must be a power
// of two; set indexes wrap modulo MAX_SETS. Write configuration only while the
// block is idle.
module set_assoc_cache_hit_miss_model #(
	parameter int MAX_SETS = 256,
	parameter int MAX_WAYS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sac_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  sac_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output sac_pkg::rsp_t                 rsp
);

	// geometry derived from the maximum set and way counts
	localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int WAYS_W = $clog2(MAX_WAYS + 1);
	localparam int WIDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int RANK_W = WIDX_W;
	localparam int ENT_W  = 2 + WAYS_W + SET_W + sac_pkg::ADDR_BITS;

	logic [ENT_W-1:0] front_ent;
	logic [ENT_W-1:0] q_data;
	logic             q_full, q_valid, q_pop, push, clear_done;

	// take an item only when the queue has room and the clearing pass is over
	assign req_ready = !q_full && clear_done;
	assign push      = req_valid && req_ready;

	sac_front #(
		.SET_W    (SET_W),
		.WAYS_W   (WAYS_W),
		.MAX_WAYS (MAX_WAYS),
		.ENT_W    (ENT_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.ent       (front_ent)
	);

	// decouple front and back so either side can stall
	sac_queue #(
		.WIDTH (ENT_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_ent),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (q_data)
	);

	sac_back #(
		.MAX_SETS (MAX_SETS),
		.MAX_WAYS (MAX_WAYS),
		.SET_W    (SET_W),
		.WAYS_W   (WAYS_W),
		.WIDX_W   (WIDX_W),
		.RANK_W   (RANK_W),
		.ENT_W    (ENT_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.ent_valid  (q_valid),
		.ent_data   (q_data),
		.ent_pop    (q_pop),
		.clear_done (clear_done),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

	// a result is either a hit or a fill, never both
	a_hit_xor_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.hit != rsp.memory_read))
		else $error("hit and memory_read disagree");

	// an eviction only happens on a miss
	a_evict_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.evicted) |-> rsp.memory_read)
		else $error("eviction without a miss");

	// no item enters while the line store is being cleared
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!clear_done |-> !req_ready)
		else $error("item accepted during clearing pass");

endmodule
